>>> rtl/owbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master package
// Types, register indexes, reset defaults and helpers shared by the core.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned TimeWidth     = 16;
   localparam int unsigned SlotWidth     = 8;
   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned BitIdxWidth   = 3;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } command_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_RESET_LOW      = 3'd0,
      REG_PRESENCE_WAIT  = 3'd1,
      REG_RESET_TAIL     = 3'd2,
      REG_SHORT_LOW      = 3'd3,
      REG_LONG_SLOT      = 3'd4,
      REG_WRITE_ZERO_REC = 3'd5,
      REG_READ_SAMPLE    = 3'd6,
      REG_READ_TAIL      = 3'd7
   } reg_index_type;

   localparam logic [TimeWidth-1:0] RESET_LOW_DEFAULT      = 16'd500;
   localparam logic [TimeWidth-1:0] PRESENCE_WAIT_DEFAULT  = 16'd100;
   localparam logic [TimeWidth-1:0] RESET_TAIL_DEFAULT     = 16'd400;
   localparam logic [SlotWidth-1:0] SHORT_LOW_DEFAULT      = 8'd2;
   localparam logic [SlotWidth-1:0] LONG_SLOT_DEFAULT      = 8'd60;
   localparam logic [SlotWidth-1:0] WRITE_ZERO_REC_DEFAULT = 8'd0;
   localparam logic [SlotWidth-1:0] READ_SAMPLE_DEFAULT    = 8'd8;
   localparam logic [SlotWidth-1:0] READ_TAIL_DEFAULT      = 8'd50;

   localparam logic [BitIdxWidth-1:0] LAST_BIT = 3'd7;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b000000001,
      PH_RST_LOW  = 9'b000000010,
      PH_RST_WAIT = 9'b000000100,
      PH_RST_TAIL = 9'b000001000,
      PH_W_LOW    = 9'b000010000,
      PH_W_REL    = 9'b000100000,
      PH_R_LOW    = 9'b001000000,
      PH_R_WAIT   = 9'b010000000,
      PH_R_TAIL   = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [TimeWidth-1:0] reset_low_time;
      logic [TimeWidth-1:0] presence_wait_time;
      logic [TimeWidth-1:0] reset_tail_time;
      logic [SlotWidth-1:0] short_low_time;
      logic [SlotWidth-1:0] long_slot_time;
      logic [SlotWidth-1:0] write_zero_recovery;
      logic [SlotWidth-1:0] read_sample_time;
      logic [SlotWidth-1:0] read_tail_time;
   } csr_type;

   typedef struct packed {
      logic                 drive_low;
      logic                 busy_res;
      logic                 done_res;
      logic                 presence;
      logic [ByteWidth-1:0] read_byte;
   } result_type;

   function automatic logic [TimeWidth-1:0] min_one_time(input logic [TimeWidth-1:0] v);
      return (v == '0) ? TimeWidth'(1) : v;
   endfunction

   function automatic logic [TimeWidth-1:0] min_one_slot(input logic [SlotWidth-1:0] v);
      return (v == '0) ? TimeWidth'(1) : TimeWidth'(v);
   endfunction

endpackage

>>> rtl/owbm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master request channel
// Valid/ready channel carrying one tick: command, write byte and bus level.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic                                valid;
   logic                                ready;
   owbm_pkg::command_type               command;
   logic [owbm_pkg::ByteWidth-1:0]      write_byte;
   logic                                bus_level;

   modport source (output valid, command, write_byte, bus_level, input ready);
   modport sink   (input valid, command, write_byte, bus_level, output ready);
endinterface

>>> rtl/owbm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master result channel
// Valid/ready channel carrying drive, status and read byte for one tick.
// ----------------------------------------------------------------------------
interface owbm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                drive_low;
   logic                                busy_res;
   logic                                done_res;
   logic                                presence;
   logic [owbm_pkg::ByteWidth-1:0]      read_byte;

   modport source (output valid, drive_low, busy_res, done_res, presence, read_byte,
                   input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, presence, read_byte,
                   output ready);
endinterface

>>> rtl/one_wire_bus_master_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master core
// A request is held in the request register, then its result is registered
// in the result register. Throughput: one request per cycle while the result
// channel is not stalled; the phase sequencer advances once per tick.
// Reset (synchronous): sequencer idle, counters and flags cleared, read byte 0,
// timing registers loaded with their defaults.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
   input  logic                                 clock,
   input  logic                                 reset,
   owbm_req_if.sink                             req_chan,
   owbm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [owbm_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [owbm_pkg::CsrDataWidth-1:0]    csr_write_data
);

   // timing registers
   owbm_pkg::csr_type                        csr_ff, csr_in;

   // request register
   logic                                     req_valid_ff, req_valid_in;
   owbm_pkg::command_type                    cmd_ff, cmd_in;
   logic [owbm_pkg::ByteWidth-1:0]           wbyte_ff, wbyte_in;
   logic                                     level_ff, level_in;

   // sequencer state
   owbm_pkg::phase_type                      phase_ff, phase_in;
   logic [owbm_pkg::TimeWidth-1:0]           count_ff, count_in;
   logic [owbm_pkg::BitIdxWidth-1:0]         bidx_ff, bidx_in;
   logic [owbm_pkg::ByteWidth-1:0]           sbyte_ff, sbyte_in;
   logic                                     pres_ff, pres_in;
   owbm_pkg::command_type                    op_ff, op_in;
   logic [owbm_pkg::ByteWidth-1:0]           rres_ff, rres_in;

   // result register
   logic                                     rsp_valid_ff, rsp_valid_in;
   owbm_pkg::result_type                     rsp_ff, rsp_in;

   logic                                     advance;
   logic                                     fire;
   logic                                     cur_bit;
   logic                                     phase_end;
   logic [owbm_pkg::TimeWidth-1:0]           count_inc;
   logic [owbm_pkg::TimeWidth-1:0]           phase_len;

   assign advance          = !rsp_valid_ff || rsp_chan.ready;
   assign fire             = req_valid_ff && advance;
   assign req_chan.ready   = !req_valid_ff || advance;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.drive_low = rsp_ff.drive_low;
   assign rsp_chan.busy_res  = rsp_ff.busy_res;
   assign rsp_chan.done_res  = rsp_ff.done_res;
   assign rsp_chan.presence  = rsp_ff.presence;
   assign rsp_chan.read_byte = rsp_ff.read_byte;

   // configuration writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (owbm_pkg::reg_index_type'(csr_index))
            owbm_pkg::REG_RESET_LOW:      csr_in.reset_low_time      = csr_write_data;
            owbm_pkg::REG_PRESENCE_WAIT:  csr_in.presence_wait_time  = csr_write_data;
            owbm_pkg::REG_RESET_TAIL:     csr_in.reset_tail_time     = csr_write_data;
            owbm_pkg::REG_SHORT_LOW:      csr_in.short_low_time      = csr_write_data[7:0];
            owbm_pkg::REG_LONG_SLOT:      csr_in.long_slot_time      = csr_write_data[7:0];
            owbm_pkg::REG_WRITE_ZERO_REC: csr_in.write_zero_recovery = csr_write_data[7:0];
            owbm_pkg::REG_READ_SAMPLE:    csr_in.read_sample_time    = csr_write_data[7:0];
            owbm_pkg::REG_READ_TAIL:      csr_in.read_tail_time      = csr_write_data[7:0];
            default:                      csr_in = csr_ff;
         endcase
      end
   end

   // request register
   always_comb begin
      req_valid_in = req_valid_ff;
      cmd_in       = cmd_ff;
      wbyte_in     = wbyte_ff;
      level_in     = level_ff;
      if (req_chan.ready) begin
         req_valid_in = req_chan.valid;
         cmd_in       = req_chan.command;
         wbyte_in     = req_chan.write_byte;
         level_in     = req_chan.bus_level;
      end
   end

   // sequencer
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bidx_in  = bidx_ff;
      sbyte_in = sbyte_ff;
      pres_in  = pres_ff;
      op_in    = op_ff;
      rres_in  = rres_ff;
      rsp_in   = '0;

      if (phase_ff == owbm_pkg::PH_IDLE && cmd_ff != owbm_pkg::CMD_NONE) begin
         op_in    = cmd_ff;
         bidx_in  = '0;
         count_in = '0;
         case (cmd_ff)
            owbm_pkg::CMD_RESET: phase_in = owbm_pkg::PH_RST_LOW;
            owbm_pkg::CMD_WRITE: begin
               sbyte_in = wbyte_ff;
               phase_in = owbm_pkg::PH_W_LOW;
            end
            default: begin
               sbyte_in = '0;
               phase_in = owbm_pkg::PH_R_LOW;
            end
         endcase
      end

      cur_bit   = sbyte_in[bidx_in];
      count_inc = count_in + owbm_pkg::TimeWidth'(1);

      case (phase_in)
         owbm_pkg::PH_RST_LOW:  phase_len = owbm_pkg::min_one_time(csr_ff.reset_low_time);
         owbm_pkg::PH_RST_WAIT: phase_len = owbm_pkg::min_one_time(csr_ff.presence_wait_time);
         owbm_pkg::PH_RST_TAIL: phase_len = csr_ff.reset_tail_time;
         owbm_pkg::PH_W_LOW:    phase_len = cur_bit ?
                                   owbm_pkg::min_one_slot(csr_ff.short_low_time) :
                                   owbm_pkg::min_one_slot(csr_ff.long_slot_time);
         owbm_pkg::PH_W_REL:    phase_len = cur_bit ?
                                   owbm_pkg::min_one_slot(csr_ff.long_slot_time) :
                                   owbm_pkg::TimeWidth'(csr_ff.write_zero_recovery);
         owbm_pkg::PH_R_LOW:    phase_len = owbm_pkg::min_one_slot(csr_ff.short_low_time);
         owbm_pkg::PH_R_WAIT:   phase_len = owbm_pkg::min_one_slot(csr_ff.read_sample_time);
         owbm_pkg::PH_R_TAIL:   phase_len = owbm_pkg::TimeWidth'(csr_ff.read_tail_time);
         default:               phase_len = owbm_pkg::TimeWidth'(1);
      endcase

      phase_end = count_inc >= phase_len;

      if (phase_in != owbm_pkg::PH_IDLE) begin
         rsp_in.busy_res  = 1'b1;
         rsp_in.drive_low = (phase_in == owbm_pkg::PH_RST_LOW) ||
                            (phase_in == owbm_pkg::PH_W_LOW) ||
                            (phase_in == owbm_pkg::PH_R_LOW);
         count_in = count_inc;
         if (phase_end) begin
            count_in = '0;
            case (phase_in)
               owbm_pkg::PH_RST_LOW: phase_in = owbm_pkg::PH_RST_WAIT;
               owbm_pkg::PH_RST_WAIT: begin
                  pres_in  = !level_ff;
                  phase_in = (csr_ff.reset_tail_time == '0) ?
                             owbm_pkg::PH_IDLE : owbm_pkg::PH_RST_TAIL;
               end
               owbm_pkg::PH_W_LOW: begin
                  if (cur_bit || csr_ff.write_zero_recovery != '0) begin
                     phase_in = owbm_pkg::PH_W_REL;
                  end else if (bidx_in == owbm_pkg::LAST_BIT) begin
                     phase_in = owbm_pkg::PH_IDLE;
                  end else begin
                     bidx_in  = bidx_in + owbm_pkg::BitIdxWidth'(1);
                     phase_in = owbm_pkg::PH_W_LOW;
                  end
               end
               owbm_pkg::PH_W_REL: begin
                  if (bidx_in == owbm_pkg::LAST_BIT) begin
                     phase_in = owbm_pkg::PH_IDLE;
                  end else begin
                     bidx_in  = bidx_in + owbm_pkg::BitIdxWidth'(1);
                     phase_in = owbm_pkg::PH_W_LOW;
                  end
               end
               owbm_pkg::PH_R_LOW: phase_in = owbm_pkg::PH_R_WAIT;
               owbm_pkg::PH_R_WAIT: begin
                  if (level_ff) begin
                     sbyte_in[bidx_in] = 1'b1;
                  end
                  if (csr_ff.read_tail_time != '0) begin
                     phase_in = owbm_pkg::PH_R_TAIL;
                  end else if (bidx_in == owbm_pkg::LAST_BIT) begin
                     phase_in = owbm_pkg::PH_IDLE;
                  end else begin
                     bidx_in  = bidx_in + owbm_pkg::BitIdxWidth'(1);
                     phase_in = owbm_pkg::PH_R_LOW;
                  end
               end
               owbm_pkg::PH_R_TAIL: begin
                  if (bidx_in == owbm_pkg::LAST_BIT) begin
                     phase_in = owbm_pkg::PH_IDLE;
                  end else begin
                     bidx_in  = bidx_in + owbm_pkg::BitIdxWidth'(1);
                     phase_in = owbm_pkg::PH_R_LOW;
                  end
               end
               default: phase_in = owbm_pkg::PH_IDLE;
            endcase
            if (phase_in == owbm_pkg::PH_IDLE) begin
               rsp_in.done_res = 1'b1;
               if (op_in == owbm_pkg::CMD_READ) begin
                  rres_in = sbyte_in;
               end
            end
         end
      end

      rsp_in.presence  = pres_in;
      rsp_in.read_byte = rres_in;

      rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.reset_low_time      <= owbm_pkg::RESET_LOW_DEFAULT;
         csr_ff.presence_wait_time  <= owbm_pkg::PRESENCE_WAIT_DEFAULT;
         csr_ff.reset_tail_time     <= owbm_pkg::RESET_TAIL_DEFAULT;
         csr_ff.short_low_time      <= owbm_pkg::SHORT_LOW_DEFAULT;
         csr_ff.long_slot_time      <= owbm_pkg::LONG_SLOT_DEFAULT;
         csr_ff.write_zero_recovery <= owbm_pkg::WRITE_ZERO_REC_DEFAULT;
         csr_ff.read_sample_time    <= owbm_pkg::READ_SAMPLE_DEFAULT;
         csr_ff.read_tail_time      <= owbm_pkg::READ_TAIL_DEFAULT;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= owbm_pkg::PH_IDLE;
         count_ff     <= '0;
         bidx_ff      <= '0;
         sbyte_ff     <= '0;
         pres_ff      <= 1'b0;
         op_ff        <= owbm_pkg::CMD_NONE;
         rres_ff      <= '0;
      end else begin
         csr_ff       <= csr_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            bidx_ff  <= bidx_in;
            sbyte_ff <= sbyte_in;
            pres_ff  <= pres_in;
            op_ff    <= op_in;
            rres_ff  <= rres_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      wbyte_ff <= wbyte_in;
      level_ff <= level_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
